@@ hw/rtl/amsg_pkg.sv @@
package amsg_pkg;

  localparam int IdxW     = 12;
  localparam int DataW    = 32;
  localparam int RootW    = 24;   // floor(sqrt(vhat << 16)) fits in 24 bits
  localparam int DenW     = 25;   // root + epsilon
  localparam int SqrtRadW = 48;
  localparam int QuotW    = 32;

  localparam logic [1:0] REG_BETA_FIRST  = 2'd0;
  localparam logic [1:0] REG_BETA_SECOND = 2'd1;
  localparam logic [1:0] REG_EPSILON     = 2'd2;
  localparam logic [1:0] REG_STEP_SCALE  = 2'd3;

  localparam logic [15:0] BETA_FIRST_RST  = 16'd58982;
  localparam logic [15:0] BETA_SECOND_RST = 16'd65470;
  localparam logic [15:0] EPSILON_RST     = 16'd1;
  localparam logic [31:0] STEP_SCALE_RST  = 32'd66;

  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic [IdxW-1:0]         element_index;
    logic signed [DataW-1:0] gradient;
  } item_t;

  typedef struct packed {
    logic signed [DataW-1:0] update_value;
    logic                    saturated;
  } result_t;

  typedef struct packed {
    logic signed [DataW-1:0] m;
    logic [DataW-1:0]        v;
    logic [DataW-1:0]        vhat;
  } mom_t;

  typedef struct packed {
    logic oor;    // index out of range
    logic sat;
    logic neg;    // sign of m
    logic zero;   // m == 0
    logic ovf;    // quotient >= 2^32 or zero denominator
  } tag_t;

  typedef struct packed {
    logic [DataW-1:0] ma;
    tag_t             tag;
  } side_t;

endpackage

@@ hw/rtl/amsg_state_mem.sv @@
module amsg_state_mem #(
  parameter int Depth = 4096,
  parameter int AddrW = 12
) (
  input  logic               clk,
  input  logic               rst,
  output logic               busy,
  input  logic [AddrW-1:0]   rd_addr,
  output amsg_pkg::mom_t     rd_data,
  input  logic               wr_en,
  input  logic [AddrW-1:0]   wr_addr,
  input  amsg_pkg::mom_t     wr_data
);
  import amsg_pkg::*;

  mom_t             mem [Depth];
  logic             clr_active;
  logic [AddrW-1:0] clr_addr;

  assign busy = clr_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AddrW'(Depth - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/amsg_sqrt.sv @@
module amsg_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [amsg_pkg::SqrtRadW-1:0] radicand,
  input  amsg_pkg::side_t               in_side,
  output logic                          out_valid,
  output logic [amsg_pkg::RootW-1:0]    root,
  output amsg_pkg::side_t               out_side
);
  import amsg_pkg::*;

  localparam int RemW = RootW + 2;

  logic                vld  [RootW+1];
  logic [SqrtRadW-1:0] x    [RootW+1];
  logic [RemW-1:0]     rem  [RootW+1];
  logic [RootW-1:0]    rt   [RootW+1];
  side_t               side [RootW+1];

  assign vld[0]  = in_valid;
  assign x[0]    = radicand;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign side[0] = in_side;

  // one result bit per stage, two radicand bits consumed
  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW+1:0] trial_rem;
    logic [RemW+1:0] trial;
    logic            fits;

    always_comb begin
      trial_rem = {rem[k], x[k][SqrtRadW-1 -: 2]};
      trial     = {2'b00, rt[k], 2'b01};
      fits      = trial_rem >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      x[k+1]    <= {x[k][SqrtRadW-3:0], 2'b00};
      rem[k+1]  <= fits ? RemW'(trial_rem - trial) : RemW'(trial_rem);
      rt[k+1]   <= {rt[k][RootW-2:0], fits};
      side[k+1] <= side[k];
    end
  end

  assign out_valid = vld[RootW];
  assign root      = rt[RootW];
  assign out_side  = side[RootW];

endmodule

@@ hw/rtl/amsg_div.sv @@
module amsg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [amsg_pkg::DenW-1:0]  den,
  input  logic [amsg_pkg::DenW-1:0]  rem_init,
  input  logic [amsg_pkg::QuotW-1:0] num_low,
  input  amsg_pkg::tag_t             in_tag,
  output logic                       out_valid,
  output logic [amsg_pkg::QuotW-1:0] quot,
  output amsg_pkg::tag_t             out_tag
);
  import amsg_pkg::*;

  logic             vld [QuotW+1];
  logic [DenW-1:0]  dv  [QuotW+1];
  logic [DenW-1:0]  rm  [QuotW+1];
  logic [QuotW-1:0] lo  [QuotW+1];
  logic [QuotW-1:0] q   [QuotW+1];
  tag_t             tg  [QuotW+1];

  assign vld[0] = in_valid;
  assign dv[0]  = den;
  assign rm[0]  = rem_init;
  assign lo[0]  = num_low;
  assign q[0]   = '0;
  assign tg[0]  = in_tag;

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    logic [DenW:0] t;
    logic          ge;

    always_comb begin
      t  = {rm[k], lo[k][QuotW-1]};
      ge = t >= {1'b0, dv[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      dv[k+1] <= dv[k];
      rm[k+1] <= ge ? DenW'(t - {1'b0, dv[k]}) : t[DenW-1:0];
      lo[k+1] <= {lo[k][QuotW-2:0], 1'b0};
      q[k+1]  <= {q[k][QuotW-2:0], ge};
      tg[k+1] <= tg[k];
    end
  end

  assign out_valid = vld[QuotW];
  assign quot      = q[QuotW];
  assign out_tag   = tg[QuotW];

endmodule

@@ hw/rtl/amsgrad_update_step.sv @@
// Channel   Ports                         Transfer
// item      start, busy, item             rising edge with start high, busy low
// result    result_valid, result          one-cycle strobe, cannot be held off
// config    cfg_write, cfg_index, cfg_data  rising edge with cfg_write high
//
// One item per cycle while busy is low; results leave in the order the items were taken.
// The datapath holds the 24-stage root pipeline and the 32-stage quotient pipeline.
// Moments live in one 96-bit wide RAM; back-to-back hits on one element are forwarded.
// After reset a clearing pass zeroes every RAM address while busy is high.
module amsgrad_update_step #(
  parameter int ELEMENT_COUNT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  amsg_pkg::item_t   item,
  output logic              result_valid,
  output amsg_pkg::result_t result,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import amsg_pkg::*;

  localparam int AddrW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

  logic [15:0] beta_first;
  logic [15:0] beta_second;
  logic [15:0] epsilon;
  logic [31:0] step_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_first  <= BETA_FIRST_RST;
      beta_second <= BETA_SECOND_RST;
      epsilon     <= EPSILON_RST;
      step_scale  <= STEP_SCALE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BETA_FIRST:  beta_first  <= cfg_data[15:0];
        REG_BETA_SECOND: beta_second <= cfg_data[15:0];
        REG_EPSILON:     epsilon     <= cfg_data[15:0];
        REG_STEP_SCALE:  step_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // p0: registered input
  logic              p0_valid;
  logic [IdxW-1:0]   p0_idx;
  logic signed [31:0] p0_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= accept;
    end
    p0_idx <= item.element_index;
    p0_g   <= item.gradient;
  end

  // p0 -> p1: gradient square and (1-b1)*g
  logic [31:0]        g_abs;
  logic [16:0]        omb1;
  logic signed [49:0] gterm1;
  logic [63:0]        sq_prod;

  always_comb begin
    g_abs   = p0_g[31] ? 32'(-p0_g) : p0_g;
    omb1    = 17'h10000 - {1'b0, beta_first};
    sq_prod = 64'(g_abs) * 64'(g_abs);
    gterm1  = $signed({33'b0, omb1}) * $signed({{18{p0_g[31]}}, p0_g});
  end

  logic               p1_valid;
  logic [IdxW-1:0]    p1_idx;
  logic               p1_oor;
  logic [63:0]        p1_sq_prod;
  logic signed [49:0] p1_gterm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= p0_valid;
    end
    p1_idx     <= p0_idx;
    p1_oor     <= 32'(p0_idx) >= 32'(ELEMENT_COUNT);
    p1_sq_prod <= sq_prod;
    p1_gterm1  <= gterm1;
  end

  // p1 -> p2: round and clip square, (1-b2)*sq; RAM read issued here
  logic [63:0] sq_round;
  logic        sq_sat;
  logic [31:0] sq;
  logic [16:0] omb2;
  logic [48:0] gterm2;

  always_comb begin
    sq_round = p1_sq_prod + 64'd32768;
    sq_sat   = sq_round[63:48] != '0;
    sq       = sq_sat ? 32'hFFFF_FFFF : sq_round[47:16];
    omb2     = 17'h10000 - {1'b0, beta_second};
    gterm2   = 49'(omb2) * 49'(sq);
  end

  logic               p2_valid;
  logic [IdxW-1:0]    p2_idx;
  logic               p2_oor;
  logic               p2_sat;
  logic signed [49:0] p2_gterm1;
  logic [48:0]        p2_gterm2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_idx    <= p1_idx;
    p2_oor    <= p1_oor;
    p2_sat    <= sq_sat;
    p2_gterm1 <= p1_gterm1;
    p2_gterm2 <= gterm2;
  end

  mom_t rd_data;
  mom_t mom_old;
  mom_t mom_new;
  logic mem_wr_en;

  logic               p3_valid;
  logic [IdxW-1:0]    p3_idx;
  logic               p3_oor;
  logic               p3_sat;
  mom_t               p3_mom;

  amsg_state_mem #(
    .Depth (ELEMENT_COUNT),
    .AddrW (AddrW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .busy    (busy),
    .rd_addr (AddrW'(p1_idx)),
    .rd_data (rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (AddrW'(p2_idx)),
    .wr_data (mom_new)
  );

  // p2: read-modify-write; the item one ahead wrote the same edge we read
  logic signed [49:0] msum;
  logic [49:0]        vsum;

  always_comb begin
    mom_old = (p3_valid && !p3_oor && p3_idx == p2_idx) ? p3_mom : rd_data;
    msum = $signed({34'b0, beta_first}) * $signed({{18{mom_old.m[31]}}, mom_old.m})
         + p2_gterm1 + 50'sd32768;
    vsum = 50'(beta_second) * 50'(mom_old.v) + 50'(p2_gterm2) + 50'd32768;
    mom_new.m    = msum[47:16];
    mom_new.v    = vsum[47:16];
    mom_new.vhat = (mom_new.v > mom_old.vhat) ? mom_new.v : mom_old.vhat;
    mem_wr_en    = p2_valid && !p2_oor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
    p3_idx <= p2_idx;
    p3_oor <= p2_oor;
    p3_sat <= p2_sat;
    p3_mom <= mom_new;
  end

  side_t sq_in_side;
  always_comb begin
    sq_in_side.ma       = p3_mom.m[31] ? 32'(-p3_mom.m) : p3_mom.m;
    sq_in_side.tag.oor  = p3_oor;
    sq_in_side.tag.sat  = p3_sat;
    sq_in_side.tag.neg  = p3_mom.m[31];
    sq_in_side.tag.zero = p3_mom.m == '0;
    sq_in_side.tag.ovf  = 1'b0;
  end

  logic             rt_valid;
  logic [RootW-1:0] rt_root;
  side_t            rt_side;

  amsg_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p3_valid),
    .radicand  ({p3_mom.vhat, 16'b0}),
    .in_side   (sq_in_side),
    .out_valid (rt_valid),
    .root      (rt_root),
    .out_side  (rt_side)
  );

  // scale |m| and form the denominator
  logic            ml_valid;
  logic [63:0]     ml_prod;
  logic [DenW-1:0] ml_den;
  tag_t            ml_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      ml_valid <= 1'b0;
    end else begin
      ml_valid <= rt_valid;
    end
    ml_prod <= 64'(rt_side.ma) * 64'(step_scale);
    ml_den  <= DenW'(rt_root) + DenW'(epsilon);
    ml_tag  <= rt_side.tag;
  end

  // add half divisor, screen quotients of 2^32 and above
  logic [63:0] num;
  logic        num_ovf;
  tag_t        pr_tag_next;

  always_comb begin
    num         = ml_prod + 64'(ml_den[DenW-1:1]);
    num_ovf     = num[63:32] >= 32'(ml_den);
    pr_tag_next = ml_tag;
    pr_tag_next.ovf = num_ovf;
  end

  logic             pr_valid;
  logic [DenW-1:0]  pr_den;
  logic [DenW-1:0]  pr_rem;
  logic [QuotW-1:0] pr_low;
  tag_t             pr_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else begin
      pr_valid <= ml_valid;
    end
    pr_den <= ml_den;
    pr_rem <= num_ovf ? '0 : num[32 +: DenW];
    pr_low <= num[31:0];
    pr_tag <= pr_tag_next;
  end

  logic             dv_valid;
  logic [QuotW-1:0] dv_quot;
  tag_t             dv_tag;

  amsg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pr_valid),
    .den       (pr_den),
    .rem_init  (pr_rem),
    .num_low   (pr_low),
    .in_tag    (pr_tag),
    .out_valid (dv_valid),
    .quot      (dv_quot),
    .out_tag   (dv_tag)
  );

  result_t res_next;

  always_comb begin
    res_next.saturated    = dv_tag.sat;
    res_next.update_value = '0;
    if (dv_tag.oor) begin
      res_next.saturated = 1'b0;
    end else if (dv_tag.zero) begin
      res_next.update_value = '0;
    end else if (dv_tag.ovf) begin
      res_next.update_value = dv_tag.neg ? NEG_LIMIT : POS_LIMIT;
      res_next.saturated    = 1'b1;
    end else if (!dv_tag.neg) begin
      if (dv_quot > POS_LIMIT) begin
        res_next.update_value = POS_LIMIT;
        res_next.saturated    = 1'b1;
      end else begin
        res_next.update_value = dv_quot;
      end
    end else begin
      if (dv_quot > NEG_LIMIT) begin
        res_next.update_value = NEG_LIMIT;
        res_next.saturated    = 1'b1;
      end else begin
        res_next.update_value = 32'(-dv_quot);
      end
    end
  end

  tag_t out_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= dv_valid;
    end
    result  <= res_next;
    out_tag <= dv_tag;
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid && busy)
    else $error("result or ready right after reset");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> !busy)
    else $error("moment write during clearing pass");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_tag.oor |-> result.update_value == '0 && !result.saturated)
    else $error("out-of-range element gave nonzero result");

  a_zero_m: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_tag.zero |-> result.update_value == '0)
    else $error("zero first moment gave nonzero step");

  a_p2_from_p1: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> $past(p1_valid))
    else $error("pipeline valid skipped a stage");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import amsg_pkg::*;

  localparam int ElemCount  = 4096;
  localparam int Latency    = 63;
  localparam int StallLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        result_valid;
  result_t     result;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_BETA_FIRST;
  logic [31:0] cfg_data = '0;

  // predictor copy of registers and moment stores
  logic [15:0] beta1_q, beta2_q, eps_q;
  logic [31:0] scale_q;
  logic signed [31:0] mom1 [ElemCount];
  logic [31:0] mom2 [ElemCount];
  logic [31:0] mom2_peak [ElemCount];

  result_t pending_updates [$];
  int mismatches = 0;
  int idle_cycles = 0;

  amsgrad_update_step #(.ELEMENT_COUNT(ElemCount)) dut (
    .clk, .rst, .start, .busy, .item, .result_valid, .result,
    .cfg_write, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic result_t amsgrad_predict(input item_t it);
    result_t res;
    longint m, g, msum, upd;
    logic [63:0] ga, sq, v, root, d, ma, mag;
    logic sat;
    int idx;
    idx = it.element_index;
    g = longint'(it.gradient);
    sat = 1'b0;
    upd = 0;
    if (idx >= ElemCount) return '0;
    msum = longint'(beta1_q) * longint'(mom1[idx])
         + (65536 - longint'(beta1_q)) * g + 32768;
    m = msum >>> 16;
    mom1[idx] = m[31:0];
    ga = (g < 0) ? -g : g;
    sq = (ga * ga + 64'd32768) >> 16;
    if (sq > 64'hFFFF_FFFF) begin
      sq = 64'hFFFF_FFFF;
      sat = 1'b1;
    end
    v = (64'(beta2_q) * 64'(mom2[idx]) + (64'd65536 - 64'(beta2_q)) * sq + 64'd32768) >> 16;
    mom2[idx] = v[31:0];
    if (v[31:0] > mom2_peak[idx]) mom2_peak[idx] = v[31:0];
    root = int_sqrt(64'(mom2_peak[idx]) << 16);
    d = root + 64'(eps_q);
    ma = (m < 0) ? -m : m;
    if (d == 0) begin
      if (m > 0) begin
        upd = 2147483647;
        sat = 1'b1;
      end else if (m < 0) begin
        upd = -2147483648;
        sat = 1'b1;
      end
    end else begin
      mag = (ma * 64'(scale_q) + (d >> 1)) / d;
      if (m >= 0) begin
        if (mag > 64'h7FFF_FFFF) begin
          mag = 64'h7FFF_FFFF;
          sat = 1'b1;
        end
        upd = longint'(mag);
      end else begin
        if (mag > 64'h8000_0000) begin
          mag = 64'h8000_0000;
          sat = 1'b1;
        end
        upd = -longint'(mag);
      end
    end
    res.update_value = upd[31:0];
    res.saturated = sat;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && result_valid) begin
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        exp_res = pending_updates.pop_front();
        if (result.update_value !== exp_res.update_value ||
            result.saturated !== exp_res.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: update exp %h got %h, sat exp %b got %b",
                     exp_res.update_value, result.update_value,
                     exp_res.saturated, result.saturated);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic [11:0] idx, input logic [31:0] grad);
    item_t it;
    it.element_index = idx;
    it.gradient = grad;
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_updates = {pending_updates, amsgrad_predict(it)};
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) pause_sender(0);
    else if (r < 95) pause_sender($urandom_range(1, 4));
    else pause_sender($urandom_range(20, 150));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_BETA_FIRST:  beta1_q = data[15:0];
      REG_BETA_SECOND: beta2_q = data[15:0];
      REG_EPSILON:     eps_q = data[15:0];
      default:         scale_q = data;
    endcase
  endtask

  task automatic set_config(input logic [15:0] b1, input logic [15:0] b2,
                            input logic [15:0] eps, input logic [31:0] scale);
    write_reg(REG_BETA_FIRST, {16'd0, b1});
    write_reg(REG_BETA_SECOND, {16'd0, b2});
    write_reg(REG_EPSILON, {16'd0, eps});
    write_reg(REG_STEP_SCALE, scale);
  endtask

  task automatic test_reset_defaults();
    send_item(12'd0, 32'd0);
    send_item(12'd0, 32'h7FFF_FFFF);
    send_item(12'd0, 32'h8000_0000);
    send_item(12'd4095, 32'h0001_0000);
    send_item(12'd4095, 32'hFFFF_FFFF);
    send_item(12'd4095, 32'd1);
    send_item(12'd1, 32'hFFFF_0000);
    send_item(12'd1, 32'hFFFF_0000);
  endtask

  // epsilon zero with a fresh element: root stays zero when g^2 rounds to zero
  task automatic test_zero_denominator();
    set_config(16'd0, 16'd65535, 16'd0, 32'h0001_0000);
    send_item(12'd100, 32'd1);
    send_item(12'd101, 32'hFFFF_FFFF);
    send_item(12'd102, 32'd0);
    pause_sender(3);
    send_item(12'd102, 32'h0002_0000);
  endtask

  task automatic test_result_clip();
    set_config(16'd65535, 16'd0, 16'd65535, 32'hFFFF_FFFF);
    send_item(12'd200, 32'h7FFF_FFFF);
    send_item(12'd201, 32'h8000_0000);
    send_item(12'd202, 32'h0000_8000);
    send_item(12'd200, 32'h1234_5678);
    send_item(12'd203, 32'hFFFF_FFFF);
  endtask

  task automatic random_phase(input int n);
    logic [11:0] idx;
    logic [31:0] grad;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      // mostly a small pool so elements see long histories and back-to-back hits
      idx = (r < 70) ? 12'($urandom_range(0, 15)) : 12'($urandom);
      r = $urandom_range(0, 99);
      if (r < 40) grad = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      else if (r < 85) grad = $urandom;
      else if (r < 90) grad = 32'h7FFF_FFFF;
      else if (r < 95) grad = 32'h8000_0000;
      else grad = 32'($signed($urandom_range(0, 8)) - 4);
      send_item(idx, grad);
      random_gap();
    end
  endtask

  task automatic test_random();
    random_phase(250);
    set_config(16'd0, 16'd0, 16'd0, 32'd0);
    random_phase(150);
    set_config(16'd65535, 16'd65535, 16'd65535, 32'hFFFF_FFFF);
    random_phase(250);
    set_config(16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    random_phase(250);
    set_config(16'd58982, 16'd65470, 16'd1, 32'h0000_1000);
    random_phase(330);
  endtask

  initial begin
    beta1_q = BETA_FIRST_RST;
    beta2_q = BETA_SECOND_RST;
    eps_q = EPSILON_RST;
    scale_q = STEP_SCALE_RST;
    for (int i = 0; i < ElemCount; i++) begin
      mom1[i] = '0;
      mom2[i] = '0;
      mom2_peak[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_zero_denominator();
    test_result_clip();
    test_random();
    drain_results();
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
